[design/rsls_pkg.sv]
// Shared types and constants for the rolling shutter line scanner.
package rsls_pkg;

	// Input item operation codes
	localparam logic [2:0] FUNC_TICK  = 3'd0;
	localparam logic [2:0] FUNC_WRITE = 3'd1;
	localparam logic [2:0] FUNC_PHASE = 3'd2;
	localparam logic [2:0] FUNC_DONE  = 3'd3;
	localparam logic [2:0] FUNC_ON    = 3'd4;

	// Period request codes
	localparam logic [1:0] LOAD_NONE   = 2'd0;
	localparam logic [1:0] LOAD_FINE   = 2'd1;
	localparam logic [1:0] LOAD_COARSE = 2'd2;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_LINE_BYTES = 3'd0;
	localparam logic [2:0] REG_CHANNELS   = 3'd1;
	localparam logic [2:0] REG_ACT_LOW    = 3'd2;
	localparam logic [2:0] REG_COARSE     = 3'd3;
	localparam logic [2:0] REG_FINE       = 3'd4;

	// Restoring remainder steps over the 15 magnitude bits of a positive phase
	localparam logic [3:0] DIV_STEPS = 4'd15;

	typedef struct packed {
		logic [2:0]         func;
		logic [2:0]         channel;
		logic [4:0]         byte_index;
		logic [7:0]         byte_data;
		logic signed [15:0] phase_amount;
		logic               on_value;
	} item_t;

	typedef struct packed {
		logic [7:0]  pin_levels;
		logic [1:0]  period_load;
		logic [15:0] period_value;
		logic        frame_started;
		logic        frame_dropped;
		logic        draw_pending;
		logic [31:0] frame_count;
		logic [31:0] lost_count;
	} result_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WORK,
		ST_FIN
	} state_t;

endpackage

[design/rolling_shutter_line_scanner.sv]
// Line scanner top level: frame buffer, channel read lane, phase remainder unit, sequencer.
//
// Items enter on req (req_valid/req_ready) and each one produces exactly one result
// on rsp (rsp_valid/rsp_ready). One item is worked on at a time.
// A tick reads the front buffer byte of every channel in use, one channel per cycle
// through the single read port of the frame memory, while a restoring remainder
// unit reduces a positive phase modulo the line width, one bit per cycle.
// The remainder unit sets the pace of a tick. Every item, a tick once its work
// is done and any other item straight after it is accepted, passes through the
// finish state, which loads its result into the output register once that is free.
// req_ready rises together with rsp_valid.
// req_ready is high whenever the sequencer is idle, also while a result waits in
// the output register; a finished item then holds until rsp_ready takes the old one.
// After reset the frame memory, CHANNEL_COUNT * 2 * LINE_BYTES_MAX bytes (512 by
// default), is cleared one byte per cycle, and req_ready stays low meanwhile.
// Configuration writes through the APB port are taken at any time, but are meant
// for idle periods; pready is tied high and reads return the register values.
module rolling_shutter_line_scanner #(
	parameter int CHANNEL_COUNT  = 8,
	parameter int LINE_BYTES_MAX = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  rsls_pkg::item_t        req,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output rsls_pkg::result_t      rsp,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [4:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import rsls_pkg::*;

	localparam int DEPTH    = CHANNEL_COUNT * 2 * LINE_BYTES_MAX;
	localparam int AW       = $clog2(DEPTH);
	localparam int LB_W     = $clog2(LINE_BYTES_MAX + 1);
	localparam int WID_W    = LB_W + 3;
	localparam int USED_MAX = (CHANNEL_COUNT < 8) ? CHANNEL_COUNT : 8;

	// configuration registers
	logic [5:0]  line_bytes_q;
	logic [3:0]  channels_q;
	logic [7:0]  act_low_q;
	logic [15:0] coarse_q;
	logic [15:0] fine_q;

	// scanner state
	logic [WID_W-1:0]   col_q;
	logic signed [15:0] phase_q;
	logic               on_q;
	logic               front_q;
	logic               wait_q;
	logic [31:0]        done_cnt_q;
	logic [31:0]        lost_cnt_q;
	logic [7:0]         pin_q;

	// per-tick result fields
	logic [1:0]  load_q;
	logic [15:0] pval_q;
	logic        started_q;
	logic        dropped_q;

	// sequencer
	state_t        state_q, state_d;
	logic [AW-1:0] clr_addr_q;
	logic          clr_step, work_done, fin_load, accept;

	// read lane
	logic [3:0]  rd_ch_q;
	logic [2:0]  rd_ch_s1;
	logic        rd_vld_s1;
	logic [7:0]  rdata_s1;
	logic        rd_issue, reads_done;
	logic [AW-1:0] rd_addr;

	// remainder unit
	logic [WID_W-1:0] rem_q;
	logic [14:0]      num_q;
	logic [3:0]       div_cnt_q;
	logic [WID_W:0]   rem_trial;

	// frame memory
	logic [7:0]    mem_q [DEPTH];
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;

	logic [LB_W-1:0]  lb_eff;
	logic [WID_W-1:0] width;
	logic [3:0]       used;
	logic             gate;

	// tick completion
	logic [WID_W-1:0]   col_next;
	logic signed [15:0] phase_next;
	logic [1:0]         load_next;
	logic [15:0]        pval_next;
	logic               wrap_next;

	// saturating phase add
	logic signed [16:0] phase_sum;
	logic signed [15:0] phase_sat;

	logic cfg_wr;

	assign accept = req_valid && req_ready;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// effective line width and channel count
	always_comb begin
		if (line_bytes_q == 6'd0) begin
			lb_eff = LB_W'(1);
		end else if (int'(line_bytes_q) > LINE_BYTES_MAX) begin
			lb_eff = LB_W'(LINE_BYTES_MAX);
		end else begin
			lb_eff = LB_W'(line_bytes_q);
		end
		width = {lb_eff, 3'b000};
		if (int'(channels_q) > USED_MAX) begin
			used = 4'(USED_MAX);
		end else begin
			used = channels_q;
		end
	end

	assign gate = (col_q < width) && on_q;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign reads_done = (rd_ch_q == used) && !rd_vld_s1;

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		clr_step  = 1'b0;
		work_done = 1'b0;
		fin_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clr_step = 1'b1;
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = (req.func == FUNC_TICK) ? ST_WORK : ST_FIN;
				end
			end
			ST_WORK: begin
				if (reads_done && div_cnt_q == DIV_STEPS) begin
					work_done = 1'b1;
					state_d   = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!rsp_valid || rsp_ready) begin
					fin_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (clr_step) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// frame memory: one write port, one registered read port
	always_comb begin
		if (clr_step) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = 8'd0;
		end else begin
			wr_en = accept && (req.func == FUNC_WRITE)
				&& (int'(req.channel) < CHANNEL_COUNT)
				&& (int'(req.byte_index) < LINE_BYTES_MAX);
			wr_addr = AW'((int'(req.channel) * 2 + int'(front_q ^ 1'b1)) * LINE_BYTES_MAX
				+ int'(req.byte_index));
			wr_data = req.byte_data;
		end
	end

	assign rd_issue = (state_q == ST_WORK) && (rd_ch_q < used);
	assign rd_addr  = AW'((int'(rd_ch_q[2:0]) * 2 + int'(front_q)) * LINE_BYTES_MAX
		+ int'(col_q >> 3));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem_q[rd_addr];
		rd_ch_s1 <= rd_ch_q[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ch_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			if (accept) begin
				rd_ch_q <= '0;
			end else if (rd_issue) begin
				rd_ch_q <= rd_ch_q + 4'd1;
			end
		end
	end

	// remainder unit: one restoring step per cycle
	assign rem_trial = {rem_q, num_q[14]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= DIV_STEPS;
			rem_q     <= '0;
			num_q     <= '0;
		end else if (accept) begin
			div_cnt_q <= '0;
			rem_q     <= '0;
			num_q     <= phase_q[14:0];
		end else if (state_q == ST_WORK && div_cnt_q != DIV_STEPS) begin
			div_cnt_q <= div_cnt_q + 4'd1;
			num_q     <= {num_q[13:0], 1'b0};
			if (rem_trial >= {1'b0, width}) begin
				rem_q <= WID_W'(rem_trial - {1'b0, width});
			end else begin
				rem_q <= rem_trial[WID_W-1:0];
			end
		end
	end

	// column step at the end of a tick
	always_comb begin
		logic [WID_W:0] sum;
		sum        = {1'b0, col_q} + {1'b0, rem_q};
		col_next   = col_q;
		phase_next = phase_q;
		if (phase_q == 16'sd0) begin
			col_next = col_q + WID_W'(1);
		end else if (!phase_q[15]) begin
			if (sum < {1'b0, width}) begin
				col_next = sum[WID_W-1:0];
			end else begin
				col_next = WID_W'(sum - {1'b0, width});
			end
			phase_next = 16'sd0;
		end else begin
			phase_next = phase_q + 16'sd1;
		end
		load_next = LOAD_NONE;
		pval_next = 16'd0;
		wrap_next = 1'b0;
		if (col_next == width - WID_W'(1)) begin
			load_next = LOAD_FINE;
			pval_next = fine_q;
		end
		if (col_next >= width) begin
			load_next = LOAD_COARSE;
			pval_next = coarse_q;
			wrap_next = 1'b1;
			col_next  = '0;
		end
	end

	always_comb begin
		phase_sum = {phase_q[15], phase_q} + {req.phase_amount[15], req.phase_amount};
		if (phase_sum[16] != phase_sum[15]) begin
			phase_sat = phase_sum[16] ? 16'sh8000 : 16'sh7FFF;
		end else begin
			phase_sat = phase_sum[15:0];
		end
	end

	// scanner state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			phase_q    <= '0;
			on_q       <= 1'b1;
			front_q    <= 1'b0;
			wait_q     <= 1'b0;
			done_cnt_q <= '0;
			lost_cnt_q <= '0;
			pin_q      <= '0;
			load_q     <= LOAD_NONE;
			pval_q     <= '0;
			started_q  <= 1'b0;
			dropped_q  <= 1'b0;
		end else begin
			if (accept) begin
				load_q    <= LOAD_NONE;
				pval_q    <= '0;
				started_q <= 1'b0;
				dropped_q <= 1'b0;
				case (req.func)
					FUNC_TICK:  pin_q   <= '0;
					FUNC_PHASE: phase_q <= phase_sat;
					FUNC_DONE:  wait_q  <= 1'b0;
					FUNC_ON:    on_q    <= req.on_value;
					default: ;
				endcase
			end
			if (rd_vld_s1) begin
				pin_q[rd_ch_s1] <= (gate & rdata_s1[col_q[2:0]]) ^ act_low_q[rd_ch_s1];
			end
			if (work_done) begin
				col_q   <= col_next;
				phase_q <= phase_next;
				load_q  <= load_next;
				pval_q  <= pval_next;
				if (wrap_next) begin
					if (!wait_q) begin
						front_q    <= ~front_q;
						done_cnt_q <= done_cnt_q + 32'd1;
						wait_q     <= 1'b1;
						started_q  <= 1'b1;
					end else begin
						lost_cnt_q <= lost_cnt_q + 32'd1;
						dropped_q  <= 1'b1;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (fin_load) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			rsp.pin_levels    <= pin_q;
			rsp.period_load   <= load_q;
			rsp.period_value  <= pval_q;
			rsp.frame_started <= started_q;
			rsp.frame_dropped <= dropped_q;
			rsp.draw_pending  <= wait_q;
			rsp.frame_count   <= done_cnt_q;
			rsp.lost_count    <= lost_cnt_q;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_bytes_q <= 6'd32;
			channels_q   <= '0;
			act_low_q    <= '0;
			coarse_q     <= '0;
			fine_q       <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_LINE_BYTES: line_bytes_q <= pwdata[5:0];
				REG_CHANNELS:   channels_q   <= pwdata[3:0];
				REG_ACT_LOW:    act_low_q    <= pwdata[7:0];
				REG_COARSE:     coarse_q     <= pwdata[15:0];
				REG_FINE:       fine_q       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_LINE_BYTES: prdata = {26'd0, line_bytes_q};
			REG_CHANNELS:   prdata = {28'd0, channels_q};
			REG_ACT_LOW:    prdata = {24'd0, act_low_q};
			REG_COARSE:     prdata = {16'd0, coarse_q};
			REG_FINE:       prdata = {16'd0, fine_q};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

[bench/rolling_shutter_line_scanner_tb.sv]
// Self-checking testbench for the rolling shutter line scanner: directed table, then random phases.
module rolling_shutter_line_scanner_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rsls_pkg::*;

	localparam int CHANNELS      = 8;
	localparam int LINE_MAX      = 32;
	localparam int STORE_DEPTH   = CHANNELS * 2 * LINE_MAX;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 220;
	localparam int SETTLE_CYCLES = 40;
	localparam int SQUEEZE_AT    = 300;
	localparam int SQUEEZE_LEN   = 400;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SHOW_LIMIT    = 40;

	localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
	localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

	localparam result_t IDLE_STATUS = '0;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		item_t       it;
		bit          typed;
		result_t     want;
		logic [2:0]  reg_idx;
		logic [15:0] value;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid;
	logic        req_ready;
	item_t       req;
	logic        rsp_valid;
	logic        rsp_ready;
	result_t     rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Scanner model: registers and state
	logic [5:0]  cfg_line_bytes;
	logic [3:0]  cfg_channels;
	logic [7:0]  cfg_act_low;
	logic [15:0] cfg_coarse;
	logic [15:0] cfg_fine;
	int unsigned col_pos;
	int          phase_acc;
	bit          disp_on;
	bit          front_sel;
	bit          draw_wait;
	logic [31:0] swaps_ok;
	logic [31:0] swaps_missed;
	logic [7:0]  pin_reg;
	logic [7:0]  line_store [STORE_DEPTH];

	result_t     predicted_results [$];
	row_t        plan [$];
	int          error_count = 0;
	int          items_accepted = 0;
	int          ticks_sent = 0;
	int          regs_written = 0;
	int          sender_calm = 0;
	bit          squeeze_done = 1'b0;
	int unsigned cycle_count = 0;

	rolling_shutter_line_scanner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #10 clk = ~clk;

	// Apply one item to the scanner model and return the result it causes.
	function automatic result_t advance_scanner(input item_t it);
		result_t     res;
		int unsigned lb;
		int unsigned width;
		int unsigned used;
		int unsigned m;
		int unsigned stored;
		int unsigned lit;
		logic [7:0]  pins;
		int          s;
		res = '0;
		case (it.func)
			FUNC_TICK: begin
				lb = (cfg_line_bytes == 0) ? 1 :
					((cfg_line_bytes > LINE_MAX) ? LINE_MAX : cfg_line_bytes);
				width = lb * 8;
				used = (cfg_channels > CHANNELS) ? CHANNELS : cfg_channels;
				pins = '0;
				for (int i = 0; i < used; i++) begin
					lit = 0;
					if (col_pos < width && disp_on) begin
						stored = 32'(line_store[(i * 2 + front_sel) * LINE_MAX
							+ (col_pos >> 3)]);
						lit = (stored >> (col_pos & 7)) & 1;
					end
					pins[i] = lit[0] ^ cfg_act_low[i];
				end
				pin_reg = pins;
				if (phase_acc == 0) begin
					col_pos = col_pos + 1;
				end else if (phase_acc > 0) begin
					m = phase_acc % width;
					if (col_pos + m < width)
						col_pos = col_pos + m;
					else
						col_pos = col_pos + m - width;
					phase_acc = 0;
				end else begin
					phase_acc = phase_acc + 1;
				end
				if (col_pos == width - 1) begin
					res.period_load = LOAD_FINE;
					res.period_value = cfg_fine;
				end
				// anything at or past the line width counts as the wrap
				if (col_pos >= width) begin
					res.period_load = LOAD_COARSE;
					res.period_value = cfg_coarse;
					col_pos = 0;
					if (!draw_wait) begin
						front_sel = ~front_sel;
						swaps_ok = swaps_ok + 1;
						draw_wait = 1'b1;
						res.frame_started = 1'b1;
					end else begin
						swaps_missed = swaps_missed + 1;
						res.frame_dropped = 1'b1;
					end
				end
			end
			FUNC_WRITE: begin
				line_store[(it.channel * 2 + (front_sel ^ 1'b1)) * LINE_MAX + it.byte_index] =
					it.byte_data;
			end
			FUNC_PHASE: begin
				s = phase_acc + $signed(it.phase_amount);
				if (s > 32767) s = 32767;
				if (s < -32768) s = -32768;
				phase_acc = s;
			end
			FUNC_DONE: draw_wait = 1'b0;
			FUNC_ON:   disp_on = it.on_value;
			default: ;
		endcase
		res.pin_levels = pin_reg;
		res.draw_pending = draw_wait;
		res.frame_count = swaps_ok;
		res.lost_count = swaps_missed;
		return res;
	endfunction

	function automatic row_t item_row(input logic [2:0] f, input logic [2:0] ch,
		input logic [4:0] idx, input logic [7:0] data, input logic [15:0] ph,
		input logic lit_on, input bit typed);
		row_t row;
		row.kind = ROW_ITEM;
		row.it = '{func: f, channel: ch, byte_index: idx, byte_data: data,
			phase_amount: ph, on_value: lit_on};
		row.typed = typed;
		row.want = IDLE_STATUS;
		row.reg_idx = REG_LINE_BYTES;
		row.value = '0;
		return row;
	endfunction

	function automatic row_t cfg_row(input logic [2:0] idx, input logic [15:0] v);
		row_t row;
		row.kind = ROW_CFG;
		row.it = '0;
		row.typed = 1'b0;
		row.want = IDLE_STATUS;
		row.reg_idx = idx;
		row.value = v;
		return row;
	endfunction

	function automatic logic [15:0] pick_period();
		int r;
		r = $urandom_range(99);
		if (r < 20) return 16'h0000;
		if (r < 40) return 16'hFFFF;
		return 16'($urandom_range(16'hFFFF));
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			error_count++;
			if (error_count <= SHOW_LIMIT)
				$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, name, want, got);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = {16'h0000, v};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_LINE_BYTES: cfg_line_bytes = v[5:0];
			REG_CHANNELS:   cfg_channels = v[3:0];
			REG_ACT_LOW:    cfg_act_low = v[7:0];
			REG_COARSE:     cfg_coarse = v;
			REG_FINE:       cfg_fine = v;
			default: ;
		endcase
		regs_written++;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Drop valid, wait for every outstanding result, then let the block go quiet.
	task automatic settle();
		@(negedge clk);
		req_valid = 1'b0;
		while (predicted_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic send_item(input item_t it, input bit typed, input result_t want);
		int      gap;
		int      r;
		result_t guess;
		r = $urandom_range(999);
		if (sender_calm > 0) begin
			sender_calm--;
			gap = 0;
		end else if (r < 15) begin
			sender_calm = $urandom_range(200, 40);
			gap = 0;
		end else if (r < 550) begin
			gap = 0;
		end else if (r < 900) begin
			gap = $urandom_range(3, 1);
		end else if (r < 985) begin
			gap = $urandom_range(15, 4);
		end else begin
			gap = $urandom_range(80, 16);
		end
		@(negedge clk);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req = it;
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
		guess = advance_scanner(it);
		predicted_results.push_back(typed ? want : guess);
		items_accepted++;
		if (it.func == FUNC_TICK) ticks_sent++;
	endtask

	// Output side: random stalls, calm stretches, and one long hold-off.
	initial begin
		int stall;
		int calm;
		int r;
		stall = 0;
		calm = 0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!squeeze_done && items_accepted >= SQUEEZE_AT) begin
				squeeze_done = 1'b1;
				rsp_ready = 1'b0;
				repeat (SQUEEZE_LEN) @(negedge clk);
			end
			if (stall > 0) begin
				stall--;
				rsp_ready = 1'b0;
			end else if (calm > 0) begin
				calm--;
				rsp_ready = 1'b1;
			end else begin
				r = $urandom_range(999);
				if (r < 4) begin
					calm = $urandom_range(300, 60);
					rsp_ready = 1'b1;
				end else if (r < 650) begin
					rsp_ready = 1'b1;
				end else begin
					rsp_ready = 1'b0;
					if (r < 960)
						stall = $urandom_range(2, 0);
					else
						stall = $urandom_range(90, 10);
				end
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (predicted_results.size() == 0) begin
				error_count++;
				if (error_count <= SHOW_LIMIT)
					$display("%0t ns: result with no item outstanding, expected none, actual 0x%0h",
						$time, rsp);
			end else begin
				want = predicted_results.pop_front();
				check_field("pin_levels", 32'(want.pin_levels), 32'(rsp.pin_levels));
				check_field("period_load", 32'(want.period_load), 32'(rsp.period_load));
				check_field("period_value", 32'(want.period_value),
					32'(rsp.period_value));
				check_field("frame_started", 32'(want.frame_started),
					32'(rsp.frame_started));
				check_field("frame_dropped", 32'(want.frame_dropped),
					32'(rsp.frame_dropped));
				check_field("draw_pending", 32'(want.draw_pending),
					32'(rsp.draw_pending));
				check_field("frame_count", want.frame_count, rsp.frame_count);
				check_field("lost_count", want.lost_count, rsp.lost_count);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int          r;
		logic [15:0] v;
		logic [63:0] raw;
		item_t       it;

		req_valid = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		cfg_line_bytes = 6'd32;
		cfg_channels = '0;
		cfg_act_low = '0;
		cfg_coarse = '0;
		cfg_fine = '0;
		col_pos = 0;
		phase_acc = 0;
		disp_on = 1'b1;
		front_sel = 1'b0;
		draw_wait = 1'b0;
		swaps_ok = '0;
		swaps_missed = '0;
		pin_reg = '0;
		for (int i = 0; i < STORE_DEPTH; i++) line_store[i] = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset registers, no channel driven: every status reads zero.
		plan.push_back(item_row(FUNC_TICK, 3'd0, 5'd0, 8'h00, 16'h0000, 1'b0, 1'b1));
		plan.push_back(item_row(FUNC_UNUSED_LO, 3'd7, 5'd31, 8'hFF, 16'hFFFF, 1'b1, 1'b1));
		plan.push_back(item_row(FUNC_UNUSED_HI, 3'd7, 5'd31, 8'hFF, 16'hFFFF, 1'b1, 1'b1));
		plan.push_back(item_row(FUNC_DONE, 3'd0, 5'd0, 8'h00, 16'h0000, 1'b0, 1'b1));
		plan.push_back(item_row(FUNC_ON, 3'd0, 5'd0, 8'h00, 16'h0000, 1'b0, 1'b1));
		plan.push_back(item_row(FUNC_TICK, 3'd0, 5'd0, 8'h00, 16'h0000, 1'b0, 1'b1));
		plan.push_back(item_row(FUNC_ON, 3'd0, 5'd0, 8'h00, 16'h0000, 1'b1, 1'b1));
		// Drive the phase into both saturation limits and back to zero.
		plan.push_back(item_row(FUNC_PHASE, 3'd0, 5'd0, 8'h00, 16'h7FFF, 1'b0, 1'b1));
		plan.push_back(item_row(FUNC_PHASE, 3'd0, 5'd0, 8'h00, 16'h7FFF, 1'b0, 1'b1));
		plan.push_back(item_row(FUNC_PHASE, 3'd0, 5'd0, 8'h00, 16'h8000, 1'b0, 1'b1));
		plan.push_back(item_row(FUNC_PHASE, 3'd0, 5'd0, 8'h00, 16'h8000, 1'b0, 1'b1));
		plan.push_back(item_row(FUNC_PHASE, 3'd0, 5'd0, 8'h00, 16'h7FFF, 1'b0, 1'b1));
		plan.push_back(item_row(FUNC_PHASE, 3'd0, 5'd0, 8'h00, 16'h0001, 1'b0, 1'b1));
		// Jump far into the line so a later shrink leaves the column outside it.
		plan.push_back(item_row(FUNC_PHASE, 3'd0, 5'd0, 8'h00, 16'd200, 1'b0, 1'b1));
		plan.push_back(item_row(FUNC_TICK, 3'd0, 5'd0, 8'h00, 16'h0000, 1'b0, 1'b1));
		plan.push_back(item_row(FUNC_WRITE, 3'd0, 5'd0, 8'h81, 16'h0000, 1'b0, 1'b1));
		plan.push_back(item_row(FUNC_WRITE, 3'd7, 5'd31, 8'hFF, 16'h0000, 1'b0, 1'b1));
		plan.push_back(item_row(FUNC_WRITE, 3'd7, 5'd0, 8'h01, 16'h0000, 1'b0, 1'b1));
		plan.push_back(cfg_row(REG_LINE_BYTES, 16'd1));
		plan.push_back(cfg_row(REG_CHANNELS, 16'd8));
		plan.push_back(cfg_row(REG_ACT_LOW, 16'h000F));
		plan.push_back(cfg_row(REG_COARSE, 16'hFFFF));
		plan.push_back(cfg_row(REG_FINE, 16'h0000));
		plan.push_back(item_row(FUNC_TICK, 3'd0, 5'd0, 8'h00, 16'h0000, 1'b0, 1'b0));
		plan.push_back(item_row(FUNC_TICK, 3'd0, 5'd0, 8'h00, 16'h0000, 1'b0, 1'b0));
		plan.push_back(item_row(FUNC_PHASE, 3'd0, 5'd0, 8'h00, 16'd13, 1'b0, 1'b0));
		plan.push_back(item_row(FUNC_TICK, 3'd0, 5'd0, 8'h00, 16'h0000, 1'b0, 1'b0));
		plan.push_back(item_row(FUNC_TICK, 3'd0, 5'd0, 8'h00, 16'h0000, 1'b0, 1'b0));
		plan.push_back(item_row(FUNC_TICK, 3'd0, 5'd0, 8'h00, 16'h0000, 1'b0, 1'b0));
		plan.push_back(item_row(FUNC_TICK, 3'd0, 5'd0, 8'h00, 16'h0000, 1'b0, 1'b0));
		plan.push_back(item_row(FUNC_DONE, 3'd0, 5'd0, 8'h00, 16'h0000, 1'b0, 1'b0));
		plan.push_back(item_row(FUNC_PHASE, 3'd0, 5'd0, 8'h00, 16'hFFFF, 1'b0, 1'b0));
		plan.push_back(item_row(FUNC_TICK, 3'd0, 5'd0, 8'h00, 16'h0000, 1'b0, 1'b0));
		plan.push_back(cfg_row(REG_LINE_BYTES, 16'd0));
		plan.push_back(cfg_row(REG_CHANNELS, 16'd15));
		plan.push_back(cfg_row(REG_ACT_LOW, 16'h00F0));
		plan.push_back(cfg_row(REG_COARSE, 16'h0000));
		plan.push_back(cfg_row(REG_FINE, 16'hFFFF));
		plan.push_back(item_row(FUNC_TICK, 3'd0, 5'd0, 8'h00, 16'h0000, 1'b0, 1'b0));
		plan.push_back(item_row(FUNC_TICK, 3'd0, 5'd0, 8'h00, 16'h0000, 1'b0, 1'b0));

		foreach (plan[n]) begin
			if (plan[n].kind == ROW_CFG) begin
				settle();
				write_reg(plan[n].reg_idx, plan[n].value);
			end else begin
				send_item(plan[n].it, plan[n].typed, plan[n].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			r = $urandom_range(99);
			if (p == 0)
				v = 16'(LINE_MAX);
			else if (p == 1)
				v = 16'd63;
			else if (r < 60)
				v = 16'($urandom_range(3, 1));
			else if (r < 70)
				v = 16'd0;
			else
				v = 16'($urandom_range(63));
			write_reg(REG_LINE_BYTES, v);
			v = ($urandom_range(99) < 50) ? 16'(CHANNELS) : 16'($urandom_range(15));
			write_reg(REG_CHANNELS, v);
			r = $urandom_range(99);
			v = (r < 20) ? 16'h0000 : ((r < 40) ? 16'h00FF : 16'($urandom_range(255)));
			write_reg(REG_ACT_LOW, v);
			write_reg(REG_COARSE, pick_period());
			write_reg(REG_FINE, pick_period());

			repeat (PHASE_ITEMS) begin
				raw = {$urandom, $urandom};
				it = raw[$bits(item_t)-1:0];
				r = $urandom_range(99);
				if (r < 45)
					it.func = FUNC_TICK;
				else if (r < 62)
					it.func = FUNC_WRITE;
				else if (r < 73)
					it.func = FUNC_PHASE;
				else if (r < 85)
					it.func = FUNC_DONE;
				else if (r < 92)
					it.func = FUNC_ON;
				else if (r < 95)
					it.func = 3'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
				else
					it.func = FUNC_TICK;
				// keep most phase steps small so the column keeps wrapping
				if (it.func == FUNC_PHASE && $urandom_range(99) < 85)
					it.phase_amount = 16'($urandom_range(40) - 12);
				if (it.func == FUNC_ON)
					it.on_value = ($urandom_range(99) < 70);
				send_item(it, 1'b0, IDLE_STATUS);
			end
		end

		settle();

		$display("Ran %0d items (%0d ticks) over %0d register writes, with a long output hold-off.",
			items_accepted, ticks_sent, regs_written);
		$display("Scanner swapped %0d frames and lost %0d.", swaps_ok, swaps_missed);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
